// ===== rtl/tdbi_pkg.sv =====
// Shared types and constants for the table-driven block interleaver.
// Used by the top level, the response queue and the port checker; no dependencies.
package tdbi_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic DIR_INTERLEAVE   = 1'b0;
   localparam logic DIR_DEINTERLEAVE = 1'b1;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION    = 4'd1;

   localparam int FRAME_LEN_W  = 11;
   localparam int PATTERN_W    = 10;
   localparam int SAMPLE_OUT_W = 16;
   localparam int POSITION_W   = 10;

   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 11'd1024;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = 2;
   localparam int RSP_CNT_W      = 3;

   typedef struct packed {
      logic signed [SAMPLE_OUT_W-1:0] sample_out;
      logic [POSITION_W-1:0]          out_position;
      logic                           frame_last;
   } rsp_item_type;

endpackage

// ===== rtl/tdbi_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module tdbi_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tdbi_rsp_fifo.sv =====
// Four-entry response queue between the bank read stage and the rsp channel.
// Depends on tdbi_pkg.
module tdbi_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tdbi_pkg::rsp_item_type push_item,
   input  logic                  pop,
   output logic                  out_valid,
   output tdbi_pkg::rsp_item_type out_item
);

   tdbi_pkg::rsp_item_type entry_ff [tdbi_pkg::RSP_FIFO_DEPTH];

   logic [tdbi_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tdbi_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tdbi_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                           do_pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & out_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + tdbi_pkg::RSP_CNT_W'(push) - tdbi_pkg::RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/table_driven_block_interleaver_unit.sv =====
// Table-driven block interleaver: pattern RAM, double-buffered sample bank RAM,
// response queue. Depends on tdbi_pkg, tdbi_ram and tdbi_rsp_fifo.
//
//  channel | handshake          | payload
//  req     | req_valid/req_stall | req_command, req_pattern_entry, req_sample
//  rsp     | rsp_valid/rsp_stall | rsp_sample_out, rsp_out_position, rsp_frame_last
//  csr     | csr_valid/csr_ready | csr_index, csr_wdata
//
// One item per cycle while req_stall is low; each result passes through the pattern
// RAM read, then the bank RAM read, then the response queue.
// Reset clears pointers and framing and sets the CSRs to their defaults; RAM contents are undefined until written.
// req_stall rises while four results are outstanding in the pipeline and queue.
// csr_ready is always high.
module table_driven_block_interleaver_unit #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_command,
   input  logic [tdbi_pkg::PATTERN_W-1:0]          req_pattern_entry,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tdbi_pkg::SAMPLE_OUT_W-1:0] rsp_sample_out,
   output logic [tdbi_pkg::POSITION_W-1:0]         rsp_out_position,
   output logic                                    rsp_frame_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tdbi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [tdbi_pkg::FRAME_LEN_W-1:0]        csr_wdata
);

   localparam int POS_W   = $clog2(MAX_FRAME);
   localparam int CNT_W   = POS_W + 1;
   localparam int CMP_W   = (CNT_W > tdbi_pkg::FRAME_LEN_W) ? CNT_W : tdbi_pkg::FRAME_LEN_W;
   localparam int BANK_AW = POS_W + 1;

   logic [tdbi_pkg::FRAME_LEN_W-1:0] frame_length_ff;
   logic                             direction_ff;

   logic [POS_W-1:0] load_ptr_ff, load_ptr_in;
   logic [POS_W-1:0] frame_pos_ff, frame_pos_in;
   logic             bank_ff, bank_in;
   logic             prev_valid_ff, prev_valid_in;
   logic [tdbi_pkg::RSP_CNT_W-1:0] pending_ff, pending_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_produce_ff;
   logic [POS_W-1:0]        s1_pos_ff;
   logic                    s1_last_ff;
   logic                    s1_bank_ff;
   logic                    s1_dir_ff;
   logic [SAMPLE_BITS-1:0]  s1_sample_ff;

   logic                    s2_valid_ff, s2_valid_in;
   logic [POS_W-1:0]        s2_pos_ff;
   logic                    s2_last_ff;

   logic [CMP_W-1:0]        eff_len;
   logic [CMP_W-1:0]        last_pos;
   logic [POS_W-1:0]        load_cur;
   logic [POS_W-1:0]        pos_cur;
   logic                    pos_is_last;
   logic                    accept;
   logic                    is_load;
   logic                    rsp_xfer;

   logic [tdbi_pkg::PATTERN_W-1:0] pattern_rd_data;
   logic [POS_W-1:0]               pattern_sat;
   logic [BANK_AW-1:0]             bank_wr_addr;
   logic [BANK_AW-1:0]             bank_rd_addr;
   logic [SAMPLE_BITS-1:0]         bank_rd_data;

   tdbi_pkg::rsp_item_type push_item;
   tdbi_pkg::rsp_item_type head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      if (frame_length_ff == '0) begin
         eff_len = CMP_W'(1);
      end else if (CMP_W'(frame_length_ff) > CMP_W'(MAX_FRAME)) begin
         eff_len = CMP_W'(MAX_FRAME);
      end else begin
         eff_len = CMP_W'(frame_length_ff);
      end
   end

   assign last_pos = eff_len - CMP_W'(1);

   assign accept   = req_valid & ~req_stall;
   assign is_load  = (req_command == tdbi_pkg::CMD_LOAD);
   assign rsp_xfer = rsp_valid & ~rsp_stall;
   assign req_stall = (pending_ff == tdbi_pkg::RSP_CNT_W'(tdbi_pkg::RSP_FIFO_DEPTH));

   assign load_cur    = (CMP_W'(load_ptr_ff) >= eff_len) ? '0 : load_ptr_ff;
   assign pos_cur     = (CMP_W'(frame_pos_ff) >= eff_len) ? '0 : frame_pos_ff;
   assign pos_is_last = (CMP_W'(pos_cur) == last_pos);

   always_comb begin
      load_ptr_in   = load_ptr_ff;
      frame_pos_in  = frame_pos_ff;
      bank_in       = bank_ff;
      prev_valid_in = prev_valid_ff;
      s1_valid_in   = 1'b0;
      if (accept) begin
         if (is_load) begin
            load_ptr_in   = (CMP_W'(load_cur) == last_pos) ? '0 : load_cur + POS_W'(1);
            frame_pos_in  = '0;
            prev_valid_in = 1'b0;
         end else begin
            s1_valid_in = 1'b1;
            if (pos_is_last) begin
               frame_pos_in  = '0;
               bank_in       = ~bank_ff;
               prev_valid_in = 1'b1;
            end else begin
               frame_pos_in = pos_cur + POS_W'(1);
            end
         end
      end
      s2_valid_in = s1_valid_ff & s1_produce_ff;
      pending_in  = pending_ff
                    + tdbi_pkg::RSP_CNT_W'(accept & ~is_load & prev_valid_ff)
                    - tdbi_pkg::RSP_CNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= tdbi_pkg::FRAME_LEN_RESET;
         direction_ff    <= tdbi_pkg::DIR_INTERLEAVE;
         load_ptr_ff     <= '0;
         frame_pos_ff    <= '0;
         bank_ff         <= 1'b0;
         prev_valid_ff   <= 1'b0;
         pending_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid & csr_ready) begin
            unique case (csr_index)
               tdbi_pkg::CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata;
               tdbi_pkg::CSR_DIRECTION:    direction_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         load_ptr_ff   <= load_ptr_in;
         frame_pos_ff  <= frame_pos_in;
         bank_ff       <= bank_in;
         prev_valid_ff <= prev_valid_in;
         pending_ff    <= pending_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_produce_ff <= prev_valid_ff;
         s1_pos_ff     <= pos_cur;
         s1_last_ff    <= pos_is_last;
         s1_bank_ff    <= bank_ff;
         s1_dir_ff     <= direction_ff;
         s1_sample_ff  <= req_sample;
      end
      if (s2_valid_in) begin
         s2_pos_ff  <= s1_pos_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   tdbi_ram #(
      .WIDTH (tdbi_pkg::PATTERN_W),
      .DEPTH (MAX_FRAME)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (accept & is_load),
      .wr_addr (load_cur),
      .wr_data (req_pattern_entry),
      .rd_en   (accept & ~is_load),
      .rd_addr (pos_cur),
      .rd_data (pattern_rd_data)
   );

   // Saturate entries at or above the frame length to the last position.
   assign pattern_sat = (CMP_W'(pattern_rd_data) >= eff_len) ? POS_W'(last_pos)
                                                            : POS_W'(pattern_rd_data);

   always_comb begin
      if (s1_dir_ff == tdbi_pkg::DIR_DEINTERLEAVE) begin
         bank_wr_addr = {s1_bank_ff, pattern_sat};
         bank_rd_addr = {~s1_bank_ff, s1_pos_ff};
      end else begin
         bank_wr_addr = {s1_bank_ff, s1_pos_ff};
         bank_rd_addr = {~s1_bank_ff, pattern_sat};
      end
   end

   tdbi_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (2 ** BANK_AW)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (bank_wr_addr),
      .wr_data (s1_sample_ff),
      .rd_en   (s2_valid_in),
      .rd_addr (bank_rd_addr),
      .rd_data (bank_rd_data)
   );

   always_comb begin
      push_item.sample_out   = $signed(tdbi_pkg::SAMPLE_OUT_W'(bank_rd_data));
      push_item.out_position = tdbi_pkg::POSITION_W'(s2_pos_ff);
      push_item.frame_last   = s2_last_ff;
   end

   tdbi_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_item (push_item),
      .pop       (~rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (head_item)
   );

   assign rsp_sample_out   = head_item.sample_out;
   assign rsp_out_position = head_item.out_position;
   assign rsp_frame_last   = head_item.frame_last;

endmodule

// ===== rtl/tdbi_checker.sv =====
// Port-level checker for the table-driven block interleaver, bound to the top level.
// Depends on tdbi_pkg.
module tdbi_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [tdbi_pkg::SAMPLE_OUT_W-1:0] rsp_sample_out,
   input logic [tdbi_pkg::POSITION_W-1:0]         rsp_out_position,
   input logic                                    rsp_frame_last
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall high with no result waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_out_position) && $stable(rsp_frame_last))
      else $error("stalled rsp transfer changed");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid |-> !req_stall)
      else $error("req_stall high while both channels idle");

endmodule

bind table_driven_block_interleaver_unit tdbi_checker u_tdbi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample_out   (rsp_sample_out),
   .rsp_out_position (rsp_out_position),
   .rsp_frame_last   (rsp_frame_last)
);
